// ===== hw/rtl/utf8_sanitize_filter_assert.svh =====
// Assertion macros shared by the text filter RTL.
// Both macros sample on clk and are disabled while rst is high.
`ifndef UTF8_SANITIZE_FILTER_ASSERT_SVH
`define UTF8_SANITIZE_FILTER_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a condition at every clock edge out of reset.
`define U8SF_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
// Check that a condition implies another in the next cycle.
`define U8SF_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define U8SF_ASSERT_ALWAYS(lbl, cond)
`define U8SF_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== hw/rtl/u8sf_pkg.sv =====
// Shared types, byte class constants and helpers for the text filter.
// No dependencies.
package u8sf_pkg;

  localparam logic [7:0] PRINT_LO   = 8'h20;
  localparam logic [7:0] PRINT_END  = 8'h7f;
  localparam logic [7:0] MASK_CONT  = 8'b11000000;
  localparam logic [7:0] CODE_CONT  = 8'b10000000;
  localparam logic [7:0] MASK_LEAD2 = 8'b11100000;
  localparam logic [7:0] CODE_LEAD2 = 8'b11000000;
  localparam logic [7:0] MASK_LEAD3 = 8'b11110000;
  localparam logic [7:0] CODE_LEAD3 = 8'b11100000;
  localparam logic [7:0] MASK_LEAD4 = 8'b11111000;
  localparam logic [7:0] CODE_LEAD4 = 8'b11110000;

  localparam int RUN_MAX = 4;

  // One input's worth of results: up to four sequence bytes, then a terminator.
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [2:0]              nb;
    logic                    eos;
  } burst_t;

  function automatic logic is_print(input logic [7:0] b);
    is_print = (b >= PRINT_LO) && (b < PRINT_END);
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    is_cont = (b & MASK_CONT) == CODE_CONT;
  endfunction

  // Sequence length announced by a lead byte, zero if not a lead byte.
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    priority if ((b & MASK_LEAD2) == CODE_LEAD2) lead_len = 3'd2;
    else if ((b & MASK_LEAD3) == CODE_LEAD3) lead_len = 3'd3;
    else if ((b & MASK_LEAD4) == CODE_LEAD4) lead_len = 3'd4;
    else lead_len = 3'd0;
  endfunction

endpackage

// ===== hw/rtl/u8sf_seq.sv =====
// Sequence tracker: holds an open UTF-8 sequence and forms the result burst.
// Depends on u8sf_pkg and utf8_sanitize_filter_assert.svh.
`include "utf8_sanitize_filter_assert.svh"
module u8sf_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  logic [7:0]      in_byte,
  input  logic            end_of_string,
  output u8sf_pkg::burst_t burst
);
  import u8sf_pkg::*;

  logic [2:0][7:0] held;
  logic [2:0][7:0] held_next;
  logic [1:0]      held_count;
  logic [1:0]      held_count_next;
  logic [2:0]      seq_len;
  logic [2:0]      seq_len_next;
  logic            fresh;
  logic [2:0]      ll;

  // Judge the byte against the open sequence and build its burst
  always_comb begin
    held_next       = held;
    held_count_next = held_count;
    seq_len_next    = seq_len;
    burst           = '0;
    fresh           = 1'b0;
    ll              = lead_len(in_byte);

    if (seq_len != 3'd0) begin
      if (is_cont(in_byte)) begin
        if ({1'b0, held_count} + 3'd1 >= seq_len) begin
          // complete: release held bytes followed by this one
          for (int i = 0; i < 3; i++) begin
            burst.bytes[i] = (2'(i) == held_count) ? in_byte : held[i];
          end
          burst.bytes[3]  = in_byte;
          burst.nb        = {1'b0, held_count} + 3'd1;
          held_count_next = 2'd0;
          seq_len_next    = 3'd0;
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (2'(i) == held_count) held_next[i] = in_byte;
          end
          held_count_next = held_count + 2'd1;
        end
      end else begin
        // broken sequence: drop held bytes, judge afresh
        held_count_next = 2'd0;
        seq_len_next    = 3'd0;
        fresh           = 1'b1;
      end
    end else if (!is_cont(in_byte)) begin
      fresh = 1'b1;
    end

    if (fresh) begin
      if (is_print(in_byte)) begin
        burst.bytes[0] = in_byte;
        burst.nb       = 3'd1;
      end else if (ll != 3'd0) begin
        seq_len_next    = ll;
        held_next[0]    = in_byte;
        held_count_next = 2'd1;
      end
    end

    // end of string: drop what is held, add the terminator
    if (end_of_string) begin
      held_count_next = 2'd0;
      seq_len_next    = 3'd0;
      burst.eos       = 1'b1;
    end
  end

  // Advance control state on each request taken
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
      seq_len    <= 3'd0;
    end else if (load) begin
      held_count <= held_count_next;
      seq_len    <= seq_len_next;
    end
  end

  // Hold bytes of the open sequence
  always_ff @(posedge clk) begin
    if (load) held <= held_next;
  end

  `U8SF_ASSERT_ALWAYS(a_idle_empty, (seq_len != 3'd0) || (held_count == 2'd0))
  `U8SF_ASSERT_ALWAYS(a_open_partial,
    (seq_len == 3'd0) || ((held_count != 2'd0) && ({1'b0, held_count} < seq_len)))
  `U8SF_ASSERT_ALWAYS(a_len_legal, (seq_len != 3'd1) && (seq_len <= 3'd4))
  `U8SF_ASSERT_ALWAYS(a_burst_size, burst.nb <= 3'd4)

endmodule

// ===== hw/rtl/utf8_sanitize_filter.sv =====
// Usage: byte-serial text filter passing printable ASCII and complete
// UTF-8 sequences.
//
// Input channel: in_valid / in_stall with in_byte and end_of_string. A
// request is taken when in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with out_byte, has_byte,
// string_done and run_last, one result per cycle while out_stall is low.
// Each input causes zero to five results; run_last marks the last one.
// A terminator (has_byte low, string_done high) closes each string.
// An input taken goes to the input register, then to the burst buffer
// whose head is the output. While out_stall is low, throughput is one
// result per cycle; an input that releases a burst of n results occupies
// the output until all n are taken; else both stages take a byte per cycle.
// When the receiver stalls, the burst buffer holds and one more input is
// taken into the input register before in_stall rises.
// Reset (rst, synchronous) empties both stages and closes any open sequence.
// Depends on u8sf_pkg, u8sf_seq and utf8_sanitize_filter_assert.svh.
`include "utf8_sanitize_filter_assert.svh"
module utf8_sanitize_filter (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       string_done,
  output logic       run_last
);
  import u8sf_pkg::*;

  logic             in_full;
  logic [7:0]       in_b;
  logic             in_e;
  logic             in_take;
  logic             out_take;
  logic             load;
  burst_t           burst;
  logic [RUN_MAX-1:0][7:0] buf_bytes;
  logic [2:0]       buf_nb;
  logic             buf_eos;

  u8sf_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .in_byte       (in_b),
    .end_of_string (in_e),
    .burst         (burst)
  );

  // Output view of the burst buffer head
  assign out_valid   = (buf_nb != 3'd0) || buf_eos;
  assign has_byte    = buf_nb != 3'd0;
  assign out_byte    = (buf_nb != 3'd0) ? buf_bytes[0] : 8'h00;
  assign string_done = (buf_nb == 3'd0) && buf_eos;
  assign run_last    = ((buf_nb == 3'd1) && !buf_eos) || (buf_nb == 3'd0);

  // Handshakes: load the next burst once the buffer drains its last result
  assign out_take = out_valid && !out_stall;
  assign load     = in_full && (!out_valid || (out_take && run_last));
  assign in_stall = in_full && !load;
  assign in_take  = in_valid && !in_stall;

  // Input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (load) begin
      in_full <= 1'b0;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_b <= in_byte;
      in_e <= end_of_string;
    end
  end

  // Burst buffer control: load a new burst or advance past the head
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_nb  <= 3'd0;
      buf_eos <= 1'b0;
    end else if (load) begin
      buf_nb  <= burst.nb;
      buf_eos <= burst.eos;
    end else if (out_take) begin
      if (buf_nb != 3'd0) buf_nb <= buf_nb - 3'd1;
      else buf_eos <= 1'b0;
    end
  end

  // Burst buffer payload: shift so the head is always entry zero
  always_ff @(posedge clk) begin
    if (load) begin
      buf_bytes <= burst.bytes;
    end else if (out_take && (buf_nb != 3'd0)) begin
      for (int i = 0; i < RUN_MAX - 1; i++) buf_bytes[i] <= buf_bytes[i+1];
    end
  end

  `U8SF_ASSERT_ALWAYS(a_load_when_free,
    !load || !out_valid || (out_take && run_last))
  `U8SF_ASSERT_NEXT(a_hold_input, in_full && !load, in_full && $stable(in_b))
  `U8SF_ASSERT_ALWAYS(a_term_shape, !out_valid || !string_done || (!has_byte && run_last))
  `U8SF_ASSERT_NEXT(a_drain_step, out_take && !run_last && !load,
    out_valid && ((buf_nb == $past(buf_nb) - 3'd1) || (buf_nb == 3'd0)))

endmodule

// ===== bench/utf8_sanitize_filter_tb.sv =====
// Self-checking bench for the byte-serial UTF-8 text filter.
// Drives directed and random text through utf8_sanitize_filter and checks every result.
// Depends on u8sf_pkg and the filter RTL.
`timescale 1ns / 1ps

module utf8_sanitize_filter_tb;
  import u8sf_pkg::*;

  localparam int N_DIRECTED = 27;
  localparam int N_RANDOM   = 75;
  localparam int QUIET_TAIL = 20;
  localparam int LONG_HOLD  = 60;
  localparam int DRAIN_WAIT = 20;

  // One filtered output beat.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       string_done;
    logic       run_last;
  } result_t;

  // One request; the typed fields give the expected result where it is obvious.
  typedef struct packed {
    logic [7:0] b;
    logic       eos;
    logic       typed;
    logic       want_byte;
    logic [7:0] want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       end_of_string = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       string_done;
  logic       run_last;

  // Shadow of the filter state.
  logic [7:0] seq_hold [3];
  logic [1:0] seq_cnt = 2'd0;
  logic [2:0] seq_len = 3'd0;

  result_t   due_results [$];
  stim_row_t stim_q [$];
  int        errors = 0;
  int        taken = 0;
  bit        quiet_tail = 1'b0;

  // Typed rows run only with no sequence open, so the shadow state stays valid.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{8'h20, 1'b0, 1'b1, 1'b1, 8'h20},  // lowest printable
    '{8'h7E, 1'b0, 1'b1, 1'b1, 8'h7E},  // highest printable
    '{8'h1F, 1'b0, 1'b1, 1'b0, 8'h00},  // control
    '{8'h7F, 1'b0, 1'b1, 1'b0, 8'h00},  // DEL
    '{8'h09, 1'b0, 1'b1, 1'b0, 8'h00},  // tab
    '{8'h80, 1'b0, 1'b1, 1'b0, 8'h00},  // stray continuation
    '{8'hF8, 1'b0, 1'b1, 1'b0, 8'h00},  // bad lead, low end
    '{8'hFF, 1'b0, 1'b1, 1'b0, 8'h00},  // bad lead, high end
    '{8'hC3, 1'b0, 1'b0, 1'b0, 8'h00},  // two-byte sequence
    '{8'hA9, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'hC3, 1'b0, 1'b0, 1'b0, 8'h00},  // broken by a new three-byte lead
    '{8'hE2, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h82, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'hAC, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'hF0, 1'b0, 1'b0, 1'b0, 8'h00},  // four-byte sequence
    '{8'h9F, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h98, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h80, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'hE2, 1'b0, 1'b0, 1'b0, 8'h00},  // broken by printable
    '{8'h41, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'hF0, 1'b0, 1'b0, 1'b0, 8'h00},  // end of string with three bytes held
    '{8'h9F, 1'b0, 1'b0, 1'b0, 8'h00},
    '{8'h98, 1'b1, 1'b0, 1'b0, 8'h00},
    '{8'hC3, 1'b0, 1'b0, 1'b0, 8'h00},  // end of string on the completing byte
    '{8'hA9, 1'b1, 1'b0, 1'b0, 8'h00},
    '{8'h41, 1'b1, 1'b1, 1'b1, 8'h41},  // printable plus terminator
    '{8'h00, 1'b1, 1'b1, 1'b0, 8'h00}   // NUL, terminator only
  };

  utf8_sanitize_filter i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .end_of_string(end_of_string),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .has_byte     (has_byte),
    .string_done  (string_done),
    .run_last     (run_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the results of one accepted request and queue them.
  function automatic void predict_filter(input logic [7:0] b, input logic eos);
    int  n0;
    bit  fresh;
    bit  cont;
    n0 = due_results.size();
    fresh = 1'b0;
    cont = (b & MASK_CONT) == CODE_CONT;
    if (seq_len != 3'd0) begin
      if (cont) begin
        if (int'(seq_cnt) + 1 >= int'(seq_len)) begin
          for (int i = 0; i < int'(seq_cnt) && i < 3; i++)
            due_results.push_back('{seq_hold[i], 1'b1, 1'b0, 1'b0});
          due_results.push_back('{b, 1'b1, 1'b0, 1'b0});
          seq_cnt = 2'd0;
          seq_len = 3'd0;
        end else begin
          seq_hold[seq_cnt] = b;
          seq_cnt = seq_cnt + 2'd1;
        end
      end else begin
        // drop the held bytes and judge this byte afresh
        seq_cnt = 2'd0;
        seq_len = 3'd0;
        fresh = 1'b1;
      end
    end else if (!cont) begin
      fresh = 1'b1;
    end

    if (fresh) begin
      if (b >= PRINT_LO && b < PRINT_END) begin
        due_results.push_back('{b, 1'b1, 1'b0, 1'b0});
      end else if ((b & MASK_LEAD2) == CODE_LEAD2) begin
        seq_len = 3'd2;
      end else if ((b & MASK_LEAD3) == CODE_LEAD3) begin
        seq_len = 3'd3;
      end else if ((b & MASK_LEAD4) == CODE_LEAD4) begin
        seq_len = 3'd4;
      end
      if (seq_len != 3'd0) begin
        seq_hold[0] = b;
        seq_cnt = 2'd1;
      end
    end

    if (eos) begin
      seq_cnt = 2'd0;
      seq_len = 3'd0;
      due_results.push_back('{8'h00, 1'b0, 1'b1, 1'b0});
    end
    if (due_results.size() > n0)
      due_results[due_results.size() - 1].run_last = 1'b1;
  endfunction

  // Build the random text: printable bytes, well-formed sequences, some broken ones and noise.
  function automatic void make_random_text();
    int pick;
    int len;
    int keep;
    logic [7:0] b;
    while (stim_q.size() < N_DIRECTED + N_RANDOM) begin
      pick = $urandom_range(0, 9);
      if (pick <= 2) begin
        stim_q.push_back('{8'($urandom_range(8'h20, 8'h7E)), 1'b0, 1'b0, 1'b0, 8'h00});
      end else if (pick <= 7) begin
        len = $urandom_range(2, 4);
        case (len)
          2:       b = 8'hC0 | 8'($urandom_range(0, 31));
          3:       b = 8'hE0 | 8'($urandom_range(0, 15));
          default: b = 8'hF0 | 8'($urandom_range(0, 7));
        endcase
        stim_q.push_back('{b, 1'b0, 1'b0, 1'b0, 8'h00});
        // broken sequences stop short and end on a non-continuation byte
        keep = (pick == 7) ? $urandom_range(0, len - 2) : len - 1;
        for (int i = 0; i < keep; i++)
          stim_q.push_back('{8'h80 | 8'($urandom_range(0, 63)), 1'b0, 1'b0, 1'b0, 8'h00});
        if (pick == 7) begin
          do b = 8'($urandom_range(0, 255)); while ((b & MASK_CONT) == CODE_CONT);
          stim_q.push_back('{b, 1'b0, 1'b0, 1'b0, 8'h00});
        end
      end else begin
        stim_q.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 8'h00});
      end
    end
    // scatter string ends, mid-sequence ones included
    for (int i = N_DIRECTED; i < stim_q.size(); i++)
      stim_q[i].eos = ($urandom_range(0, 9) == 0);
  endfunction

  // Sender: walk the directed table, then the random text.
  initial begin
    bit calm;
    stim_row_t row;
    calm = 1'b0;
    for (int i = 0; i < N_DIRECTED; i++)
      stim_q.push_back(directed_rows[i]);
    make_random_text();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < stim_q.size(); i++) begin
      row = stim_q[i];
      if (i >= stim_q.size() - QUIET_TAIL)
        quiet_tail = 1'b1;
      if ($urandom_range(0, 14) == 0)
        calm = !calm;

      // once, pause until the filter has delivered everything owed; else pause at random
      if (i == N_DIRECTED + 50) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (due_results.size() != 0);
      end else if (!quiet_tail && !calm && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end

      in_valid      <= 1'b1;
      in_byte       <= row.b;
      end_of_string <= row.eos;
      @(posedge clk);
      while (in_stall) @(posedge clk);

      // request taken at this edge
      taken++;
      if (row.typed) begin
        if (row.want_byte)
          due_results.push_back('{row.want, 1'b1, 1'b0, !row.eos});
        if (row.eos)
          due_results.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
      end else begin
        predict_filter(row.b, row.eos);
      end
    end
    in_valid <= 1'b0;

    // drain, then keep watching for anything unexpected before finishing
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Receiver: check each accepted result, then choose the next stall.
  int      stall_left = 0;
  bit      long_done = 1'b0;
  bit      rx_calm = 1'b0;
  result_t got;
  result_t want;

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{out_byte, has_byte, string_done, run_last};
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result byte=%02h has=%b done=%b last=%b",
                   $time, got.out_byte, got.has_byte, got.string_done, got.run_last);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch exp byte=%02h has=%b done=%b last=%b, got byte=%02h has=%b done=%b last=%b",
                     $time, want.out_byte, want.has_byte, want.string_done, want.run_last,
                     got.out_byte, got.has_byte, got.string_done, got.run_last);
            errors++;
          end
        end
      end

      if ($urandom_range(0, 49) == 0)
        rx_calm = !rx_calm;
      // hold off long once so the filter backs up into its input
      if (!long_done && taken >= N_DIRECTED + 20) begin
        long_done = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !quiet_tail && !rx_calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10);
      end

      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Guard against a hang.
  initial begin
    #1000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
